>>> hdl/perspective_point_projector_macros.svh
// Assertion macros shared by the projector RTL.
`ifndef PERSPECTIVE_POINT_PROJECTOR_MACROS_SVH
`define PERSPECTIVE_POINT_PROJECTOR_MACROS_SVH

// Checked only while out of reset.
`define PPP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PPP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ppp_pkg.sv
// Shared constants, types and codes of the perspective point projector.
package ppp_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int COEF_COUNT  = 12;
	localparam int SLOT_W      = 4;
	localparam int DIM_W       = 13;
	localparam int CFG_IDX_W   = 1;

	// x, y, w accumulators: three floored products plus one coefficient
	localparam int ACC_W       = 2 * DATA_W - FRAC_BITS + 2;
	localparam int MAG_W       = ACC_W - 1;
	localparam int NUM_W       = MAG_W + DIM_W;
	localparam int DEN_W       = ACC_W;
	localparam int QUO_W       = DATA_W + FRAC_BITS;
	localparam int CMP_W       = DEN_W + DATA_W;
	localparam int DIV_STEPS   = (QUO_W + 1) / 2;
	localparam int LO_W        = 2 * DIV_STEPS;
	localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
	localparam int SUM_W       = QUO_W + 3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [ACC_W-1:0] W_MIN = ACC_W'((2 ** FRAC_BITS + 999) / 1000);
	localparam logic signed [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0] HALF_FIX = SUM_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2147483647);
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_PROJECT = 1'b1
	} op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEWPORT_WIDTH  = 1'b0,
		REG_VIEWPORT_HEIGHT = 1'b1
	} cfg_reg_e;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DOT,
		BK_DRAIN,
		BK_SCALE,
		BK_START,
		BK_DIV,
		BK_FIN
	} bk_state_t;

	typedef struct packed {
		op_e                       kind;
		logic [SLOT_W-1:0]         slot;
		logic signed [DATA_W-1:0]  value;
		logic signed [DATA_W-1:0]  px;
		logic signed [DATA_W-1:0]  py;
		logic signed [DATA_W-1:0]  pz;
	} cmd_t;

	typedef struct packed {
		logic              done;
		logic              sat;
		logic [QUO_W-1:0]  quo;
	} div_res_t;

endpackage

>>> hdl/ppp_if.sv
// Item and result channel interfaces of the projector.
interface ppp_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  op;
	logic [ppp_pkg::SLOT_W-1:0]            coef_index;
	logic signed [ppp_pkg::DATA_W-1:0]     coef_value;
	logic signed [ppp_pkg::DATA_W-1:0]     point_x;
	logic signed [ppp_pkg::DATA_W-1:0]     point_y;
	logic signed [ppp_pkg::DATA_W-1:0]     point_z;

	modport source (output valid, op, coef_index, coef_value, point_x, point_y, point_z,
		input ready);
	modport sink (input valid, op, coef_index, coef_value, point_x, point_y, point_z,
		output ready);
endinterface

interface ppp_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ppp_pkg::DATA_W-1:0]     screen_x;
	logic signed [ppp_pkg::DATA_W-1:0]     screen_y;
	logic                                  visible;

	modport source (output valid, screen_x, screen_y, visible, input ready);
	modport sink (input valid, screen_x, screen_y, visible, output ready);
endinterface

>>> hdl/ppp_front.sv
// Front end: accepts items, drops bad loads, queues commands for the back end.
`include "perspective_point_projector_macros.svh"

module ppp_front (
	input  logic           clk,
	input  logic           arst_n,
	ppp_in_if.sink         item,
	output ppp_pkg::cmd_t  cmd,
	output logic           cmd_valid,
	input  logic           cmd_ready
);

	ppp_pkg::cmd_t                   entries_q [ppp_pkg::QUEUE_DEPTH];
	logic [ppp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ppp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ppp_pkg::QCNT_W-1:0]      count_q;
	ppp_pkg::cmd_t                   new_cmd;
	logic                            accept;
	logic                            push;
	logic                            pop;
	logic                            bad_load;

	assign item.ready = (count_q != ppp_pkg::QCNT_W'(ppp_pkg::QUEUE_DEPTH));
	assign accept     = item.valid && item.ready;
	assign bad_load   = (item.op == ppp_pkg::OP_LOAD) &&
		(item.coef_index >= ppp_pkg::SLOT_W'(ppp_pkg::COEF_COUNT));
	assign push       = accept && !bad_load;
	assign pop        = cmd_valid && cmd_ready;

	always_comb begin
		new_cmd.kind  = ppp_pkg::op_e'(item.op);
		new_cmd.slot  = item.coef_index;
		new_cmd.value = item.coef_value;
		new_cmd.px    = item.point_x;
		new_cmd.py    = item.point_y;
		new_cmd.pz    = item.point_z;
	end

	assign cmd_valid = (count_q != '0);
	assign cmd       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ppp_pkg::QPTR_W'(ppp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ppp_pkg::QPTR_W'(ppp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PPP_ASSERT(a_count_bound, count_q <= ppp_pkg::QCNT_W'(ppp_pkg::QUEUE_DEPTH), "queue overfilled")
	`PPP_ASSERT(a_count_up, push && !pop |=> count_q == $past(count_q) + 1'b1, "push lost")
	`PPP_ASSERT(a_head_slot, cmd_valid && cmd.kind == ppp_pkg::OP_LOAD |-> cmd.slot < ppp_pkg::SLOT_W'(ppp_pkg::COEF_COUNT), "bad slot queued")

endmodule

>>> hdl/ppp_div.sv
// Restoring divider, two quotient bits per cycle, with overflow detect.
module ppp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppp_pkg::NUM_W-1:0]     num,
	input  logic [ppp_pkg::DEN_W-1:0]     den,
	output ppp_pkg::div_res_t             res
);

	logic [ppp_pkg::DEN_W-1:0]             rem_q;
	logic [ppp_pkg::LO_W-1:0]              lo_q;
	logic [ppp_pkg::STEP_CNT_W-1:0]        cnt_q;
	logic                                  busy_q;
	logic                                  done_q;
	logic                                  sat_q;
	logic [ppp_pkg::NUM_W+ppp_pkg::FRAC_BITS-1:0] dvd;
	logic                                  overflow;
	logic [ppp_pkg::DEN_W:0]               r_a;
	logic [ppp_pkg::DEN_W:0]               r_b;
	logic                                  ge_a;
	logic                                  ge_b;
	logic [ppp_pkg::DEN_W-1:0]             rem_a;
	logic [ppp_pkg::DEN_W-1:0]             rem_b;

	assign dvd      = {num, {ppp_pkg::FRAC_BITS{1'b0}}};
	assign overflow = ppp_pkg::CMP_W'(num) >= {den, {ppp_pkg::DATA_W{1'b0}}};

	always_comb begin
		r_a   = {rem_q, lo_q[ppp_pkg::LO_W-1]};
		ge_a  = r_a >= {1'b0, den};
		rem_a = ge_a ? ppp_pkg::DEN_W'(r_a - {1'b0, den}) : ppp_pkg::DEN_W'(r_a);
		r_b   = {rem_a, lo_q[ppp_pkg::LO_W-2]};
		ge_b  = r_b >= {1'b0, den};
		rem_b = ge_b ? ppp_pkg::DEN_W'(r_b - {1'b0, den}) : ppp_pkg::DEN_W'(r_b);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ppp_pkg::DEN_W'(dvd >> ppp_pkg::LO_W);
			lo_q  <= dvd[ppp_pkg::LO_W-1:0];
		end else if (busy_q) begin
			rem_q <= rem_b;
			lo_q  <= {lo_q[ppp_pkg::LO_W-3:0], ge_a, ge_b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			sat_q  <= overflow;
			busy_q <= !overflow;
			done_q <= overflow;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ppp_pkg::STEP_CNT_W'(ppp_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign res = '{done: done_q, sat: sat_q, quo: lo_q[ppp_pkg::QUO_W-1:0]};

endmodule

>>> hdl/ppp_back.sv
// Back end: coefficient store, dot products, divides, viewport map, result register.
`include "perspective_point_projector_macros.svh"

module ppp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ppp_pkg::cmd_t                 cmd,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [ppp_pkg::DIM_W-1:0]     vp_width,
	input  logic [ppp_pkg::DIM_W-1:0]     vp_height,
	ppp_out_if.source                     result
);

	ppp_pkg::bk_state_t                    state_q;
	ppp_pkg::bk_state_t                    next_state;

	logic signed [ppp_pkg::DATA_W-1:0]     coef_q [ppp_pkg::COEF_COUNT];
	logic signed [ppp_pkg::DATA_W-1:0]     px_q;
	logic signed [ppp_pkg::DATA_W-1:0]     py_q;
	logic signed [ppp_pkg::DATA_W-1:0]     pz_q;
	logic [ppp_pkg::SLOT_W-1:0]            cnt_q;
	logic signed [ppp_pkg::DATA_W-1:0]     operand;

	logic signed [2*ppp_pkg::DATA_W-1:0]   prod_s1;
	logic                                  prod_vld_s1;
	logic [1:0]                            prow_s1;
	logic signed [ppp_pkg::ACC_W-1:0]      acc_q [3];

	logic [ppp_pkg::MAG_W-1:0]             mag_x;
	logic [ppp_pkg::MAG_W-1:0]             mag_y;
	logic                                  vis;
	logic [ppp_pkg::NUM_W-1:0]             nx_q;
	logic [ppp_pkg::NUM_W-1:0]             ny_q;
	logic [ppp_pkg::DEN_W-1:0]             den_q;
	logic                                  xneg_q;
	logic                                  yneg_q;
	logic                                  vis_q;

	logic                                  div_start;
	ppp_pkg::div_res_t                     divx;
	ppp_pkg::div_res_t                     divy;

	logic signed [ppp_pkg::SUM_W-1:0]      base_x;
	logic signed [ppp_pkg::SUM_W-1:0]      base_y;
	logic signed [ppp_pkg::SUM_W-1:0]      qx;
	logic signed [ppp_pkg::SUM_W-1:0]      qy;
	logic signed [ppp_pkg::SUM_W-1:0]      sx_full;
	logic signed [ppp_pkg::SUM_W-1:0]      sy_full;
	logic signed [ppp_pkg::DATA_W-1:0]     sx_val;
	logic signed [ppp_pkg::DATA_W-1:0]     sy_val;

	logic                                  out_load;
	logic                                  out_valid_q;
	logic signed [ppp_pkg::DATA_W-1:0]     sx_q;
	logic signed [ppp_pkg::DATA_W-1:0]     sy_q;
	logic                                  vis_out_q;

	function automatic logic signed [ppp_pkg::DATA_W-1:0] sat32(
		input logic signed [ppp_pkg::SUM_W-1:0] v
	);
		logic signed [ppp_pkg::SUM_W-1:0] c;
		c = v;
		if (v > ppp_pkg::SAT_HI) begin
			c = ppp_pkg::SAT_HI;
		end else if (v < ppp_pkg::SAT_LO) begin
			c = ppp_pkg::SAT_LO;
		end
		return ppp_pkg::DATA_W'(c);
	endfunction

	// ---- sequencer
	always_comb begin
		next_state = state_q;
		unique case (state_q)
			ppp_pkg::BK_IDLE: begin
				if (cmd_valid && cmd.kind == ppp_pkg::OP_PROJECT) begin
					next_state = ppp_pkg::BK_DOT;
				end
			end
			ppp_pkg::BK_DOT: begin
				if (cnt_q == ppp_pkg::SLOT_W'(ppp_pkg::COEF_COUNT - 1)) begin
					next_state = ppp_pkg::BK_DRAIN;
				end
			end
			ppp_pkg::BK_DRAIN: next_state = ppp_pkg::BK_SCALE;
			ppp_pkg::BK_SCALE: next_state = vis ? ppp_pkg::BK_START : ppp_pkg::BK_FIN;
			ppp_pkg::BK_START: next_state = ppp_pkg::BK_DIV;
			ppp_pkg::BK_DIV: begin
				// an overflowing divider finishes at once, so wait for both
				if (divx.done && divy.done) begin
					next_state = ppp_pkg::BK_FIN;
				end
			end
			ppp_pkg::BK_FIN: begin
				if (!out_valid_q || result.ready) begin
					next_state = ppp_pkg::BK_IDLE;
				end
			end
			default: next_state = ppp_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ppp_pkg::BK_IDLE:  cmd_ready = 1'b1;
			ppp_pkg::BK_START: div_start = 1'b1;
			ppp_pkg::BK_FIN:   out_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppp_pkg::BK_IDLE;
		end else begin
			state_q <= next_state;
		end
	end

	// ---- coefficient store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppp_pkg::COEF_COUNT; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cmd_ready && cmd_valid && cmd.kind == ppp_pkg::OP_LOAD) begin
			coef_q[cmd.slot] <= cmd.value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid && cmd.kind == ppp_pkg::OP_PROJECT) begin
			px_q <= cmd.px;
			py_q <= cmd.py;
			pz_q <= cmd.pz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ppp_pkg::BK_DOT) begin
			cnt_q <= cnt_q + 1'b1;
		end else begin
			cnt_q <= '0;
		end
	end

	// ---- dot products: slot = row*4 + column, column 3 is the offset term
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    operand = px_q;
			2'd1:    operand = py_q;
			2'd2:    operand = pz_q;
			default: operand = ppp_pkg::ONE_FIX;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef_q[cnt_q] * operand;
		prow_s1 <= cnt_q[3:2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= (state_q == ppp_pkg::BK_DOT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid && cmd.kind == ppp_pkg::OP_PROJECT) begin
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end else if (prod_vld_s1) begin
			acc_q[prow_s1] <= acc_q[prow_s1] +
				ppp_pkg::ACC_W'(prod_s1 >>> ppp_pkg::FRAC_BITS);
		end
	end

	// ---- visibility and numerator scaling
	assign vis   = acc_q[2] >= ppp_pkg::W_MIN;
	assign mag_x = acc_q[0][ppp_pkg::ACC_W-1] ? ppp_pkg::MAG_W'(-acc_q[0]) :
		ppp_pkg::MAG_W'(acc_q[0]);
	assign mag_y = acc_q[1][ppp_pkg::ACC_W-1] ? ppp_pkg::MAG_W'(-acc_q[1]) :
		ppp_pkg::MAG_W'(acc_q[1]);

	always_ff @(posedge clk) begin
		if (state_q == ppp_pkg::BK_SCALE) begin
			nx_q   <= ppp_pkg::NUM_W'(mag_x) * ppp_pkg::NUM_W'(vp_width);
			ny_q   <= ppp_pkg::NUM_W'(mag_y) * ppp_pkg::NUM_W'(vp_height);
			den_q  <= {acc_q[2][ppp_pkg::ACC_W-2:0], 1'b0};
			xneg_q <= acc_q[0][ppp_pkg::ACC_W-1];
			yneg_q <= acc_q[1][ppp_pkg::ACC_W-1];
			vis_q  <= vis;
		end
	end

	ppp_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (nx_q),
		.den    (den_q),
		.res    (divx)
	);

	ppp_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ny_q),
		.den    (den_q),
		.res    (divy)
	);

	// ---- viewport map and clamp
	always_comb begin
		base_x  = ppp_pkg::SUM_W'(vp_width >> 1) << ppp_pkg::FRAC_BITS;
		base_y  = ppp_pkg::SUM_W'(vp_height >> 1) << ppp_pkg::FRAC_BITS;
		qx      = ppp_pkg::SUM_W'(divx.quo);
		qy      = ppp_pkg::SUM_W'(divy.quo);
		if (xneg_q) begin
			qx = -qx;
		end
		if (yneg_q) begin
			qy = -qy;
		end
		sx_full = base_x + qx + ppp_pkg::HALF_FIX;
		sy_full = base_y - (qy + ppp_pkg::HALF_FIX);
		if (!vis_q) begin
			sx_val = '0;
			sy_val = '0;
		end else begin
			if (divx.sat) begin
				sx_val = xneg_q ? ppp_pkg::DATA_W'(ppp_pkg::SAT_LO) :
					ppp_pkg::DATA_W'(ppp_pkg::SAT_HI);
			end else begin
				sx_val = sat32(sx_full);
			end
			if (divy.sat) begin
				sy_val = yneg_q ? ppp_pkg::DATA_W'(ppp_pkg::SAT_HI) :
					ppp_pkg::DATA_W'(ppp_pkg::SAT_LO);
			end else begin
				sy_val = sat32(sy_full);
			end
		end
	end

	// ---- result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			sx_q      <= sx_val;
			sy_q      <= sy_val;
			vis_out_q <= vis_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.screen_x = sx_q;
	assign result.screen_y = sy_q;
	assign result.visible  = vis_out_q;

	`PPP_ASSERT_ALWAYS(a_hidden_zero, out_valid_q && !vis_out_q |-> sx_q == '0 && sy_q == '0, "hidden point with nonzero coordinates")
	`PPP_ASSERT(a_dividers_lockstep, !divx.sat && !divy.sat |-> divx.done == divy.done, "dividers out of step")
	`PPP_ASSERT(a_dot_slot, state_q == ppp_pkg::BK_DOT |-> cnt_q < ppp_pkg::SLOT_W'(ppp_pkg::COEF_COUNT), "dot slot out of range")
	`PPP_ASSERT(a_prod_origin, prod_vld_s1 |-> $past(state_q) == ppp_pkg::BK_DOT, "stray product")

endmodule

>>> hdl/perspective_point_projector.sv
// Top level: viewport registers, front queue and projection back end.
// Load transaction: written to the coefficient store as it leaves the two-entry queue; gives no result.
// Project transaction: back-end states DOT, DRAIN, SCALE, START, DIV, FIN (no START or DIV
// behind the eye); shared multiplier for the dot products, then the two radix-4 dividers.
// No new command is taken until a project ends in FIN; loads one per cycle while idle.
// Reset clears coefficients to zero, viewport to 1920x1080, queue and result empty.
module perspective_point_projector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ppp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppp_pkg::DIM_W-1:0]         cfg_data,
	ppp_in_if.sink                            item,
	ppp_out_if.source                         result
);

	logic [ppp_pkg::DIM_W-1:0]  vp_width_q;
	logic [ppp_pkg::DIM_W-1:0]  vp_height_q;
	ppp_pkg::cmd_t              cmd;
	logic                       cmd_valid;
	logic                       cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_width_q  <= ppp_pkg::WIDTH_RESET;
			vp_height_q <= ppp_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (ppp_pkg::cfg_reg_e'(cfg_index))
				ppp_pkg::REG_VIEWPORT_WIDTH:  vp_width_q  <= cfg_data;
				ppp_pkg::REG_VIEWPORT_HEIGHT: vp_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ppp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	ppp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.vp_width  (vp_width_q),
		.vp_height (vp_height_q),
		.result    (result)
	);

endmodule
